@@ src/ir_mkm_pkg.sv @@
// ----------------------------------------------------------------------------
// ir_mkm_pkg
// Shared types and constants of the IR Morse keying modulator: transaction
// payloads, configuration register set, register indexes and reset values.
// ----------------------------------------------------------------------------
package ir_mkm_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUBCARRIER_DIVIDE = 3'd0,
        REG_BLINK_LIMIT       = 3'd1,
        REG_REARM_STEPS       = 3'd2,
        REG_LONG_PRESS_LIMIT  = 3'd3,
        REG_SPACE_LIMIT       = 3'd4,
        REG_DIT_LIMIT         = 3'd5,
        REG_MESSAGE_COUNT     = 3'd6
    } cfg_index_t;

    localparam logic [7:0]  RST_SUBCARRIER_DIVIDE = 8'd50;
    localparam logic [15:0] RST_BLINK_LIMIT       = 16'd800;
    localparam logic [15:0] RST_REARM_STEPS       = 16'd40;
    localparam logic [23:0] RST_LONG_PRESS_LIMIT  = 24'd16000;
    localparam logic [19:0] RST_SPACE_LIMIT       = 20'd800;
    localparam logic [15:0] RST_DIT_LIMIT         = 16'd80;
    localparam logic [8:0]  RST_MESSAGE_COUNT     = 9'd4;

    localparam logic [23:0] HOLD_MAX    = 24'hFFFFFF;
    localparam logic [19:0] ELEMENT_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [7:0]  subcarrier_divide;
        logic [15:0] blink_limit;
        logic [15:0] rearm_steps;
        logic [23:0] long_press_limit;
        logic [19:0] space_limit;
        logic [15:0] dit_limit;
        logic [8:0]  message_count;
    } cfg_t;

    typedef struct packed {
        logic       button_down;
        logic [3:0] element_dits;
    } in_item_t;

    typedef struct packed {
        logic       ir_led_on;
        logic       status_led_on;
        logic       fetch_element;
        logic [7:0] message_number;
        logic       message_restart;
        logic       manual_key;
    } out_item_t;

endpackage

@@ src/ir_mkm_cfg.sv @@
// ----------------------------------------------------------------------------
// ir_mkm_cfg
// Configuration register file: decodes the write port into the register set.
// ----------------------------------------------------------------------------
module ir_mkm_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ir_mkm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ir_mkm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ir_mkm_pkg::cfg_t                    cfg
);
    import ir_mkm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_SUBCARRIER_DIVIDE: cfg_next.subcarrier_divide = cfg_wr_data[7:0];
                REG_BLINK_LIMIT:       cfg_next.blink_limit       = cfg_wr_data[15:0];
                REG_REARM_STEPS:       cfg_next.rearm_steps       = cfg_wr_data[15:0];
                REG_LONG_PRESS_LIMIT:  cfg_next.long_press_limit  = cfg_wr_data[23:0];
                REG_SPACE_LIMIT:       cfg_next.space_limit       = cfg_wr_data[19:0];
                REG_DIT_LIMIT:         cfg_next.dit_limit         = cfg_wr_data[15:0];
                REG_MESSAGE_COUNT:     cfg_next.message_count     = cfg_wr_data[8:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.subcarrier_divide <= RST_SUBCARRIER_DIVIDE;
            cfg_reg.blink_limit       <= RST_BLINK_LIMIT;
            cfg_reg.rearm_steps       <= RST_REARM_STEPS;
            cfg_reg.long_press_limit  <= RST_LONG_PRESS_LIMIT;
            cfg_reg.space_limit       <= RST_SPACE_LIMIT;
            cfg_reg.dit_limit         <= RST_DIT_LIMIT;
            cfg_reg.message_count     <= RST_MESSAGE_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/ir_mkm_step.sv @@
// ----------------------------------------------------------------------------
// ir_mkm_step
// Modulator state and its per-tick update: carrier and subcarrier phases,
// status blink, button debounce and hold timing, Morse element timing.
// ----------------------------------------------------------------------------
module ir_mkm_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ir_mkm_pkg::cfg_t      cfg,
    input  logic                  advance,
    input  ir_mkm_pkg::in_item_t  item,
    output ir_mkm_pkg::out_item_t result
);
    import ir_mkm_pkg::*;

    logic [2:0]  phase_bits_reg,       phase_bits_next;
    logic [7:0]  subcarrier_count_reg, subcarrier_count_next;
    logic [15:0] blink_count_reg,      blink_count_next;
    logic        status_level_reg,     status_level_next;
    logic [23:0] hold_time_reg,        hold_time_next;
    logic [15:0] debounce_count_reg,   debounce_count_next;
    logic        key_latched_reg,      key_latched_next;
    logic [19:0] element_count_reg,    element_count_next;
    logic [19:0] element_limit_reg,    element_limit_next;
    logic [7:0]  selected_message_reg, selected_message_next;

    logic [7:0]  sc_inc;
    logic [8:0]  sel_inc;
    logic [19:0] ec_inc;
    logic [19:0] dit_product;
    logic        pressed;
    logic        fetch;
    logic        restart;

    assign dit_product = 20'(cfg.dit_limit) * 20'(item.element_dits);

    always_comb begin
        phase_bits_next       = phase_bits_reg ^ 3'b001;
        subcarrier_count_next = subcarrier_count_reg;
        blink_count_next      = blink_count_reg;
        status_level_next     = status_level_reg;
        hold_time_next        = hold_time_reg;
        debounce_count_next   = debounce_count_reg;
        key_latched_next      = key_latched_reg;
        element_count_next    = element_count_reg;
        element_limit_next    = element_limit_reg;
        selected_message_next = selected_message_reg;
        pressed               = 1'b0;
        fetch                 = 1'b0;
        restart               = 1'b0;
        sel_inc               = 9'd0;
        ec_inc                = 20'd0;
        sc_inc                = subcarrier_count_reg + 8'd1;

        if (sc_inc < cfg.subcarrier_divide) begin
            subcarrier_count_next = sc_inc;
        end else begin
            subcarrier_count_next = 8'd0;
            phase_bits_next       = phase_bits_next ^ 3'b010;

            if (blink_count_reg == cfg.blink_limit) begin
                blink_count_next  = 16'd0;
                status_level_next = ~status_level_reg;
            end else begin
                blink_count_next = blink_count_reg + 16'd1;
            end

            if (item.button_down) begin
                if (hold_time_reg != HOLD_MAX) begin
                    hold_time_next = hold_time_reg + 24'd1;
                end
                pressed             = (debounce_count_reg == 16'd0);
                debounce_count_next = cfg.rearm_steps;
            end else begin
                hold_time_next = 24'd0;
                if (debounce_count_reg != 16'd0) begin
                    debounce_count_next = debounce_count_reg - 16'd1;
                end
            end

            if (hold_time_next > cfg.long_press_limit) begin
                key_latched_next = 1'b1;
            end

            if (key_latched_next) begin
                phase_bits_next[2] = (hold_time_next == 24'd0);
            end else begin
                if (pressed) begin
                    sel_inc               = {1'b0, selected_message_reg} + 9'd1;
                    selected_message_next = (sel_inc >= cfg.message_count) ? 8'd0
                                                                           : sel_inc[7:0];
                    restart               = 1'b1;
                    phase_bits_next[2]    = 1'b1;
                    element_count_next    = 20'd0;
                    element_limit_next    = cfg.space_limit;
                end

                ec_inc = (element_count_next != ELEMENT_MAX) ? element_count_next + 20'd1
                                                             : element_count_next;
                if (ec_inc < element_limit_next) begin
                    element_count_next = ec_inc;
                end else begin
                    element_count_next = 20'd0;
                    fetch              = 1'b1;
                    if ({1'b0, selected_message_next} >= cfg.message_count) begin
                        selected_message_next = 8'd0;
                    end
                    if (item.element_dits == 4'd0) begin
                        phase_bits_next[2] = 1'b1;
                        element_limit_next = cfg.space_limit;
                    end else begin
                        phase_bits_next[2] = ~phase_bits_next[2];
                        element_limit_next = dit_product;
                    end
                end
            end
        end

        result.ir_led_on       = (phase_bits_reg == 3'b000);
        result.status_led_on   = status_level_next;
        result.fetch_element   = fetch;
        result.message_number  = selected_message_next;
        result.message_restart = restart;
        result.manual_key      = key_latched_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_bits_reg       <= 3'b000;
            subcarrier_count_reg <= 8'd0;
            blink_count_reg      <= 16'd0;
            status_level_reg     <= 1'b0;
            hold_time_reg        <= 24'd0;
            debounce_count_reg   <= 16'd0;
            key_latched_reg      <= 1'b0;
            element_count_reg    <= 20'd0;
            element_limit_reg    <= RST_SPACE_LIMIT;
            selected_message_reg <= 8'd0;
        end else if (advance) begin
            phase_bits_reg       <= phase_bits_next;
            subcarrier_count_reg <= subcarrier_count_next;
            blink_count_reg      <= blink_count_next;
            status_level_reg     <= status_level_next;
            hold_time_reg        <= hold_time_next;
            debounce_count_reg   <= debounce_count_next;
            key_latched_reg      <= key_latched_next;
            element_count_reg    <= element_count_next;
            element_limit_reg    <= element_limit_next;
            selected_message_reg <= selected_message_next;
        end
    end

`ifndef SYNTH
    a_key_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        key_latched_reg |=> key_latched_reg)
        else $error("manual key mode dropped");

    a_no_fetch_in_manual: assert property (@(posedge aclk) disable iff (!aresetn)
        result.fetch_element |-> !result.manual_key)
        else $error("element fetch in manual key mode");

    a_no_restart_in_manual: assert property (@(posedge aclk) disable iff (!aresetn)
        result.message_restart |-> !result.manual_key)
        else $error("message restart in manual key mode");

    a_hold_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(hold_time_reg) && $stable(element_count_reg))
        else $error("state moved without a transaction");
`endif

endmodule

@@ src/ir_morse_keying_modulator_core.sv @@
// ----------------------------------------------------------------------------
// ir_morse_keying_modulator_core
// IR Morse keying modulator: one carrier tick per input transaction, one
// result transaction per tick with LED drive, status and message control.
//
//   channel  ports                               payload
//   s_       s_valid  s_ready  s_data            button_down, element_dits
//   m_       m_valid  m_ready  m_data            ir_led_on .. manual_key
//   cfg_     cfg_wr_en cfg_index cfg_wr_data     register write, no wait
//
// One transaction per cycle sustained while m_ready holds; an s_ accept
// loads in_data_reg, then the state update loads out_data_reg and sets m_valid.
// The state update is one pass of logic with a single 16x4 multiply.
// Synchronous active-low reset sets all but the data regs; no clearing pass.
// A stalled m_ channel holds its result while the input register still
// takes one more transaction.
// ----------------------------------------------------------------------------
module ir_morse_keying_modulator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ir_mkm_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ir_mkm_pkg::out_item_t               m_data,
    input  logic                                cfg_wr_en,
    input  logic [ir_mkm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ir_mkm_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import ir_mkm_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;

    ir_mkm_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ir_mkm_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule
